FILE: rtl/urma_pkg.sv
`default_nettype none

package urma_pkg;

  // framing constants
  localparam logic [7:0]  SYNC_BYTE     = 8'hFE;
  localparam logic [15:0] NO_DATA       = 16'hFFFF;
  localparam int          READ_FLAG_BIT = 7;

  // longest run of results one input can cause
  localparam int RUN_MAX = 5;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  // result kind codes
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // input function codes
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_RX_BYTE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_BUSY     = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] read_data;
    logic [1:0]  status;
  } result_t;

  // run of results produced by one input transaction
  typedef struct packed {
    result_t [RUN_MAX-1:0] items;
    logic [CNT_W-1:0]      count;
  } run_t;

endpackage

`default_nettype wire

FILE: rtl/urma_req_if.sv
`default_nettype none

interface urma_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        is_read;
  logic [6:0]  reg_address;
  logic [15:0] write_value;
  logic [7:0]  rx_byte;

  modport source (
    output valid, func, is_read, reg_address, write_value, rx_byte,
    input  ready
  );

  modport sink (
    input  valid, func, is_read, reg_address, write_value, rx_byte,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/urma_rsp_if.sv
`default_nettype none

interface urma_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] read_data;
  logic [1:0]  status;

  modport source (
    output valid, kind, tx_byte, last, read_data, status,
    input  ready
  );

  modport sink (
    input  valid, kind, tx_byte, last, read_data, status,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/urma_ctrl.sv
`default_nettype none

module urma_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          func,
  input  wire logic          is_read,
  input  wire logic [6:0]    reg_address,
  input  wire logic [15:0]   write_value,
  input  wire logic [7:0]    rx_byte,
  output urma_pkg::run_t     run
);
  import urma_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } phase_t;

  phase_t     phase, phase_next;
  logic       pending_is_read, pending_is_read_next;
  logic [7:0] sent_checksum, sent_checksum_next;
  logic [7:0] got_high_byte, got_high_byte_next;
  logic [7:0] got_low_byte, got_low_byte_next;

  logic [7:0] abyte;
  logic [7:0] hi_byte;
  logic [7:0] lo_byte;
  logic [7:0] wr_sum;
  logic [7:0] rd_sum;

  // request framing bytes
  assign abyte   = {is_read, reg_address};
  assign hi_byte = write_value[15:8];
  assign lo_byte = write_value[7:0];
  assign wr_sum  = hi_byte + lo_byte + abyte;
  assign rd_sum  = got_high_byte + got_low_byte;

  function automatic result_t tx_item(input logic [7:0] b, input logic lst);
    result_t r;
    r.kind      = KIND_TX;
    r.tx_byte   = b;
    r.last      = lst;
    r.read_data = 16'h0000;
    r.status    = ST_OK;
    return r;
  endfunction

  function automatic result_t report_item(input logic [15:0] d, input status_t s);
    result_t r;
    r.kind      = KIND_REPORT;
    r.tx_byte   = 8'h00;
    r.last      = 1'b1;
    r.read_data = d;
    r.status    = s;
    return r;
  endfunction

  // result run and next state for the current transaction
  always_comb begin
    run                  = '0;
    phase_next           = phase;
    pending_is_read_next = pending_is_read;
    sent_checksum_next   = sent_checksum;
    got_high_byte_next   = got_high_byte;
    got_low_byte_next    = got_low_byte;
    if (func == FUNC_REQUEST) begin
      if (phase != PH_IDLE) begin
        run.items[0] = report_item(NO_DATA, ST_BUSY);
        run.count    = CNT_W'(1);
      end else begin
        run.items[0]         = tx_item(SYNC_BYTE, 1'b0);
        run.items[1]         = tx_item(abyte, 1'b0);
        pending_is_read_next = is_read;
        phase_next           = PH_FIRST;
        if (is_read) begin
          run.items[2]       = tx_item(abyte, 1'b1);
          run.count          = CNT_W'(3);
          sent_checksum_next = abyte;
        end else begin
          run.items[2]       = tx_item(hi_byte, 1'b0);
          run.items[3]       = tx_item(lo_byte, 1'b0);
          run.items[4]       = tx_item(wr_sum, 1'b1);
          run.count          = CNT_W'(5);
          sent_checksum_next = wr_sum;
        end
      end
    end else if (phase != PH_IDLE) begin
      if (!pending_is_read) begin
        phase_next   = PH_IDLE;
        run.items[0] = report_item(NO_DATA,
                                   (rx_byte == sent_checksum) ? ST_OK : ST_MISMATCH);
        run.count    = CNT_W'(1);
      end else begin
        case (phase)
          PH_FIRST: begin
            got_high_byte_next = rx_byte;
            phase_next         = PH_SECOND;
          end
          PH_SECOND: begin
            got_low_byte_next = rx_byte;
            phase_next        = PH_THIRD;
          end
          default: begin
            phase_next = PH_IDLE;
            run.count  = CNT_W'(1);
            if (rx_byte == rd_sum) begin
              run.items[0] = report_item({got_high_byte, got_low_byte}, ST_OK);
            end else begin
              run.items[0] = report_item(NO_DATA, ST_MISMATCH);
            end
          end
        endcase
      end
    end
  end

  // transaction state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      pending_is_read <= 1'b0;
      sent_checksum   <= 8'h00;
      got_high_byte   <= 8'h00;
      got_low_byte    <= 8'h00;
    end else if (accept) begin
      phase           <= phase_next;
      pending_is_read <= pending_is_read_next;
      sent_checksum   <= sent_checksum_next;
      got_high_byte   <= got_high_byte_next;
      got_low_byte    <= got_low_byte_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/urma_emit.sv
`default_nettype none

module urma_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire urma_pkg::run_t run,
  output logic               in_ready,
  output urma_pkg::result_t  head,
  output logic               head_valid,
  input  wire logic          head_ready
);
  import urma_pkg::*;

  result_t [RUN_MAX-1:0] slots;
  logic [CNT_W-1:0]      count;
  logic                  pop;

  assign head       = slots[0];
  assign head_valid = (count != '0);
  assign pop        = head_valid && head_ready;

  // a new run may enter when the queue is empty or its last queued result leaves this cycle
  assign in_ready = (count == '0) || ((count == CNT_W'(1)) && head_ready);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= run.count;
    end else if (pop) begin
      count <= count - CNT_W'(1);
    end
  end

  // result slots, head at index zero
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= run.items;
    end else if (pop) begin
      for (int i = 0; i < RUN_MAX - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RUN_MAX))
    else $error("run count out of range");

  a_last_marks_end: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (head.last == (count == CNT_W'(1))))
    else $error("last flag does not match end of run");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (load && (count != '0)) |-> ((count == CNT_W'(1)) && pop))
    else $error("run loaded over pending results");

  a_report_alone: assert property (@(posedge clk) disable iff (rst)
    (head_valid && (head.kind == KIND_REPORT)) |-> (count == CNT_W'(1)))
    else $error("report not alone in its run");
`endif

endmodule

`default_nettype wire

FILE: rtl/uart_register_access_master_unit.sv
// Host side of a checksummed byte-framed register access link.
// req channel: func 0 is a register request (is_read, reg_address,
// write_value); func 1 hands in a byte received from the device (rx_byte).
// rsp channel: kind 0 items carry a byte to transmit in tx_byte; kind 1
// items are completion reports with read_data and status (0 ok,
// 1 checksum mismatch, 2 busy). last marks the final item of the run
// caused by one request transaction.
// The first result of a transaction is valid the cycle after it is
// accepted. A read request emits 3 bytes, a write request 5, each other
// transaction at most one report; results leave one per cycle while rsp
// is ready, and req is ready again in the cycle its last result is taken.
// Received bytes that cause no result need no rsp slot.
// Reset clears the pending transaction and empties the result queue.
// When the receiver stalls, the current result holds and req stays low
// until the final item of the run is taken.
`default_nettype none

module uart_register_access_master_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  urma_req_if.sink   req,
  urma_rsp_if.source rsp
);
  import urma_pkg::*;

  run_t    run;
  result_t head;
  logic    accept;
  logic    in_ready;

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;

  // request decode and link state
  urma_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (req.func),
    .is_read     (req.is_read),
    .reg_address (req.reg_address),
    .write_value (req.write_value),
    .rx_byte     (req.rx_byte),
    .run         (run)
  );

  // result queue toward rsp
  urma_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .run        (run),
    .in_ready   (in_ready),
    .head       (head),
    .head_valid (rsp.valid),
    .head_ready (rsp.ready)
  );

  assign rsp.kind      = head.kind;
  assign rsp.tx_byte   = head.tx_byte;
  assign rsp.last      = head.last;
  assign rsp.read_data = head.read_data;
  assign rsp.status    = head.status;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import urma_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 100;
  localparam int DRAIN_CYCLES  = 12;

  // device bytes still awaited by the pending transaction
  typedef enum logic [1:0] {
    AWAIT_NONE   = 2'd0,
    AWAIT_FIRST  = 2'd1,
    AWAIT_SECOND = 2'd2,
    AWAIT_THIRD  = 2'd3
  } await_t;

  logic clk = 1'b0;
  logic rst;

  urma_req_if req_ch ();
  urma_rsp_if rsp_ch ();

  uart_register_access_master_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the link state
  await_t     await_phase;
  logic       pend_read;
  logic [7:0] sent_ck;
  logic [7:0] got_hi;
  logic [7:0] got_lo;

  result_t link_results_due[$];

  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned work_items;
  int unsigned burst_left;
  bit          sender_bursty;
  bit          rsp_always_ready;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[uart_register_access_master_unit] ERROR");
      $finish;
    end
  end

  function automatic result_t make_result(logic k, logic [7:0] tx, logic lst,
                                          logic [15:0] data, status_t st);
    result_t r;
    r.kind      = k;
    r.tx_byte   = tx;
    r.last      = lst;
    r.read_data = data;
    r.status    = st;
    return r;
  endfunction

  // frame a request or collect a device byte, queueing the results it causes
  function automatic void frame_and_collect(logic f, logic rd, logic [6:0] addr,
                                            logic [15:0] value, logic [7:0] rx);
    logic [7:0] abyte;
    logic [7:0] sum;
    if (f == FUNC_REQUEST) begin
      if (await_phase != AWAIT_NONE) begin
        link_results_due.push_back(make_result(KIND_REPORT, 8'h00, 1'b1, NO_DATA, ST_BUSY));
        return;
      end
      abyte = {1'b0, addr};
      abyte[READ_FLAG_BIT] = rd;
      link_results_due.push_back(make_result(KIND_TX, SYNC_BYTE, 1'b0, 16'h0, ST_OK));
      link_results_due.push_back(make_result(KIND_TX, abyte, 1'b0, 16'h0, ST_OK));
      pend_read   = rd;
      await_phase = AWAIT_FIRST;
      if (rd) begin
        sent_ck = abyte;
        link_results_due.push_back(make_result(KIND_TX, abyte, 1'b1, 16'h0, ST_OK));
      end else begin
        sent_ck = value[15:8] + value[7:0] + abyte;
        link_results_due.push_back(make_result(KIND_TX, value[15:8], 1'b0, 16'h0, ST_OK));
        link_results_due.push_back(make_result(KIND_TX, value[7:0], 1'b0, 16'h0, ST_OK));
        link_results_due.push_back(make_result(KIND_TX, sent_ck, 1'b1, 16'h0, ST_OK));
      end
      return;
    end
    // device byte
    if (await_phase == AWAIT_NONE)
      return;
    if (!pend_read) begin
      await_phase = AWAIT_NONE;
      link_results_due.push_back(make_result(KIND_REPORT, 8'h00, 1'b1, NO_DATA,
                                             (rx == sent_ck) ? ST_OK : ST_MISMATCH));
      return;
    end
    case (await_phase)
      AWAIT_FIRST: begin
        got_hi      = rx;
        await_phase = AWAIT_SECOND;
      end
      AWAIT_SECOND: begin
        got_lo      = rx;
        await_phase = AWAIT_THIRD;
      end
      default: begin
        await_phase = AWAIT_NONE;
        sum = got_hi + got_lo;
        if (rx == sum)
          link_results_due.push_back(make_result(KIND_REPORT, 8'h00, 1'b1,
                                                 {got_hi, got_lo}, ST_OK));
        else
          link_results_due.push_back(make_result(KIND_REPORT, 8'h00, 1'b1,
                                                 NO_DATA, ST_MISMATCH));
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // compare each response transaction with the oldest queued result
  always @(posedge clk) begin : check_rsp
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (link_results_due.size() == 0) begin
        $error("unexpected response: kind %0d tx_byte 0x%0h", rsp_ch.kind, rsp_ch.tx_byte);
        mismatches++;
      end else begin
        want = link_results_due.pop_front();
        check_field("kind", 16'(want.kind), 16'(rsp_ch.kind));
        check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_ch.tx_byte));
        check_field("last", 16'(want.last), 16'(rsp_ch.last));
        check_field("read_data", want.read_data, rsp_ch.read_data);
        check_field("status", 16'(want.status), 16'(rsp_ch.status));
      end
    end
  end

  // receiver stalls follow an 8-bit ready pattern, redrawn each time it wraps
  initial begin : drive_rsp_ready
    logic [7:0]  pattern;
    int unsigned pos;
    rsp_ch.ready <= 1'b0;
    pattern = 8'hFF;
    pos     = 0;
    forever begin
      @(posedge clk);
      if (pos == 0) begin
        case ($urandom_range(0, 3))
          0:       pattern = 8'hFF;
          1:       pattern = 8'h80;
          default: pattern = 8'($urandom) | 8'h01;
        endcase
      end
      rsp_ch.ready <= rsp_always_ready ? 1'b1 : pattern[pos];
      pos = (pos + 1) % 8;
    end
  end

  // drive one transaction on req and predict its results at acceptance
  task automatic send_item(logic f, logic rd, logic [6:0] addr, logic [15:0] value,
                           logic [7:0] rx);
    int unsigned gap;
    req_ch.valid       <= 1'b1;
    req_ch.func        <= f;
    req_ch.is_read     <= rd;
    req_ch.reg_address <= addr;
    req_ch.write_value <= value;
    req_ch.rx_byte     <= rx;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    if (!(f == FUNC_RX_BYTE && await_phase == AWAIT_NONE))
      work_items++;
    frame_and_collect(f, rd, addr, value, rx);
    // bursts separated by random gaps
    if (sender_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_request(logic rd, logic [6:0] addr, logic [15:0] value);
    send_item(FUNC_REQUEST, rd, addr, value, 8'($urandom));
  endtask

  task automatic send_byte(logic [7:0] rx);
    send_item(FUNC_RX_BYTE, 1'($urandom), 7'($urandom), 16'($urandom), rx);
  endtask

  task automatic send_busy_request();
    send_request(1'($urandom), 7'($urandom), 16'($urandom));
  endtask

  // bytes from the device with nothing pending are dropped
  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // write framing at the field extremes, good and bad echo
  task automatic test_write_requests();
    send_request(1'b0, 7'd0, 16'h0000);
    send_byte(sent_ck);
    send_request(1'b0, 7'd127, 16'hFFFF);
    send_byte(sent_ck ^ 8'h01);
  endtask

  // read framing, checksum wrap and mismatch
  task automatic test_read_requests();
    send_request(1'b1, 7'd127, 16'hFFFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_request(1'b1, 7'd0, 16'h0000);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h00);
  endtask

  // new requests while a write or a read is pending are rejected
  task automatic test_busy_requests();
    send_request(1'b0, 7'h55, 16'hA5C3);
    send_busy_request();
    send_byte(sent_ck);
    send_request(1'b1, 7'h2A, 16'h1234);
    send_busy_request();
    send_byte(8'h80);
    send_busy_request();
    send_byte(8'h7F);
    send_busy_request();
    send_byte(8'hFF);
  endtask

  // one exchange: mostly well formed, with strays, busy noise and corruption
  task automatic run_random_exchange();
    logic       rd;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] ck;
    rd = 1'($urandom);
    if ($urandom_range(0, 9) == 0)
      send_byte(8'($urandom));
    send_request(rd, 7'($urandom), 16'($urandom));
    if ($urandom_range(0, 7) == 0)
      send_busy_request();
    // abandoned exchange leaves the link busy for the next one
    if ($urandom_range(0, 11) == 0)
      return;
    if (rd) begin
      hi = 8'($urandom);
      lo = 8'($urandom);
      send_byte(hi);
      if ($urandom_range(0, 9) == 0)
        send_busy_request();
      send_byte(lo);
      if ($urandom_range(0, 9) == 0)
        send_busy_request();
      ck = hi + lo;
    end else begin
      ck = sent_ck;
    end
    if ($urandom_range(0, 4) == 0)
      ck = ck ^ 8'($urandom_range(1, 255));
    send_byte(ck);
  endtask

  task automatic test_random_traffic();
    work_items = 0;
    while (work_items < RANDOM_ITEMS) begin
      // first stretch runs with no idling on either side
      sender_bursty    = (work_items >= 30);
      rsp_always_ready = (work_items < 30) || (work_items >= 80);
      run_random_exchange();
    end
  endtask

  // sequence
  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= FUNC_REQUEST;
    req_ch.is_read     <= 1'b0;
    req_ch.reg_address <= 7'd0;
    req_ch.write_value <= 16'h0;
    req_ch.rx_byte     <= 8'h0;
    await_phase      = AWAIT_NONE;
    pend_read        = 1'b0;
    sent_ck          = 8'h00;
    got_hi           = 8'h00;
    got_lo           = 8'h00;
    mismatches       = 0;
    cycle_count      = 0;
    work_items       = 0;
    burst_left       = 0;
    sender_bursty    = 1'b0;
    rsp_always_ready = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_bytes();
    test_write_requests();
    rsp_always_ready = 1'b0;
    test_read_requests();
    sender_bursty = 1'b1;
    test_busy_requests();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (link_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("[uart_register_access_master_unit] OK");
    else
      $display("[uart_register_access_master_unit] ERROR");
    $finish;
  end

endmodule
